[src/rtd_pkg.sv]
// ----------------------------------------------------------------------------
// rtd_pkg
// Types, codes and constants shared by the run-length texture decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

  localparam int unsigned MAX_CHANNELS = 4;

  // Magic 'C','R','T','1'
  localparam logic [7:0] MAGIC_0 = 8'h43;
  localparam logic [7:0] MAGIC_1 = 8'h52;
  localparam logic [7:0] MAGIC_2 = 8'h54;
  localparam logic [7:0] MAGIC_3 = 8'h31;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_PULL = 2'd1,
    REQ_END  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    PH_MAGIC    = 3'd0,
    PH_HEADER   = 3'd1,
    PH_RUNCOUNT = 3'd2,
    PH_RUNLEN   = 3'd3,
    PH_RUNPIX   = 3'd4,
    PH_DONE     = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_MAGIC    = 3'd1,
    ST_BAD_CHANNELS = 3'd2,
    ST_OVERFLOW     = 3'd3,
    ST_INCOMPLETE   = 3'd4,
    ST_REFUSED      = 3'd5
  } status_e;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // Decoder state
  typedef struct packed {
    phase_e      phase;
    logic [2:0]  byte_cnt;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  channels;
    logic [31:0] total;
    logic [31:0] runs_left;
    logic [15:0] run_len;
    logic [15:0] pending;
    logic [31:0] pixel_word;
    logic [31:0] written;
    status_e     error;
  } state_t;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] pixel_value;
    logic [31:0] pixel_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  channel_count;
    status_e     status;
    logic        last_pixel;
  } result_t;

endpackage

[src/rle_texture_decoder_core.sv]
// ----------------------------------------------------------------------------
// rle_texture_decoder_core
// Run-length coded texture stream decoder, one file byte or request per item.
// ----------------------------------------------------------------------------
// Takes a 'CRT1' texture file one byte per item (req_type 0), hands out the
// pixels of each decoded run on pull items (req_type 1) and reports status on
// an end item (req_type 2). The decode state is updated at acceptance and any
// result lands in a single output register, so a new item is accepted every
// cycle as long as the output register is empty or is being drained in the
// same cycle. A result appears on the outputs the cycle after its item. Bad
// magic, bad channel count and run overflow are sticky until reset; a byte
// sent while a run's pixels are still pending is refused with status 5 and
// changes nothing. The image size product is a 16x16 multiply taken from the
// header registers when the reserved byte arrives.
// ----------------------------------------------------------------------------
module rle_texture_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [31:0] pixel_value_o,
  output logic [31:0] pixel_index_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [2:0]  channel_count_o,
  output logic [2:0]  status_o,
  output logic        last_pixel_o
);

  rtd_pkg::state_t  state_q, state_d;
  rtd_pkg::result_t step_res;
  rtd_pkg::result_t out_res;
  logic             step_valid;
  logic             in_acc;

  // accept whenever the result register is free or draining
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  rtd_step u_step (
    .state_i     (state_q),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .state_o     (state_d),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  // decode state: every field here is control, so all of it resets
  // (magic phase and no error are both the all-zero codes)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  rtd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_acc && step_valid),
    .res_i       (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o          = out_res.kind;
  assign pixel_value_o   = out_res.pixel_value;
  assign pixel_index_o   = out_res.pixel_index;
  assign image_width_o   = out_res.image_width;
  assign image_height_o  = out_res.image_height;
  assign channel_count_o = out_res.channel_count;
  assign status_o        = out_res.status;
  assign last_pixel_o    = out_res.last_pixel;

  // errors never clear once set
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.error != rtd_pkg::ST_OK) |=> (state_q.error == $past(state_q.error)))
    else $error("decode error changed after being set");

  // pending pixels only exist between runs or after the last one
  a_pending_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pending != 16'd0) |->
      ((state_q.phase == rtd_pkg::PH_RUNLEN) || (state_q.phase == rtd_pkg::PH_DONE)))
    else $error("pixels pending outside run boundary");

  // a pixel result never carries a status code
  a_pixel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == rtd_pkg::KIND_PIXEL)) |-> (status_o == rtd_pkg::ST_OK))
    else $error("pixel result with nonzero status");

  // empty result register must never stall the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

[src/rtd_step.sv]
// ----------------------------------------------------------------------------
// rtd_step
// Next-state and result logic for one item of the texture decoder.
// ----------------------------------------------------------------------------
module rtd_step (
  input  rtd_pkg::state_t  state_i,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       data_byte_i,
  output rtd_pkg::state_t  state_o,
  output logic             res_valid_o,
  output rtd_pkg::result_t res_o
);

  logic [2:0]  n;
  logic [2:0]  n_inc;
  logic [4:0]  sh;
  logic [7:0]  magic;
  logic [31:0] byte_ext;
  logic        has_err;
  logic        overflow;
  logic        last;
  logic        done_ok;

  assign n        = state_i.byte_cnt;
  assign n_inc    = n + 3'd1;
  assign sh       = {n[1:0], 3'b000};
  assign byte_ext = {24'd0, data_byte_i};
  assign has_err  = (state_i.error != rtd_pkg::ST_OK);
  assign overflow = ({1'b0, state_i.written} + {17'd0, state_i.run_len})
                    > {1'b0, state_i.total};
  assign last     = ({1'b0, state_i.written} + 33'd1) == {1'b0, state_i.total};
  assign done_ok  = (state_i.phase == rtd_pkg::PH_DONE) && (state_i.pending == 16'd0)
                    && (state_i.written == state_i.total);

  always_comb begin
    case (n[1:0])
      2'd0:    magic = rtd_pkg::MAGIC_0;
      2'd1:    magic = rtd_pkg::MAGIC_1;
      2'd2:    magic = rtd_pkg::MAGIC_2;
      default: magic = rtd_pkg::MAGIC_3;
    endcase
  end

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    // status-shaped result by default
    res_o.kind          = rtd_pkg::KIND_STATUS;
    res_o.pixel_value   = 32'd0;
    res_o.pixel_index   = state_i.written;
    res_o.image_width   = state_i.width;
    res_o.image_height  = state_i.height;
    res_o.channel_count = state_i.channels;
    res_o.status        = rtd_pkg::ST_OK;
    res_o.last_pixel    = 1'b0;

    case (req_type_i)
      rtd_pkg::REQ_BYTE: begin
        if (!has_err) begin
          if (state_i.pending != 16'd0) begin
            res_valid_o  = 1'b1;
            res_o.status = rtd_pkg::ST_REFUSED;
          end else begin
            case (state_i.phase)
              rtd_pkg::PH_MAGIC: begin
                if (data_byte_i != magic) begin
                  state_o.error = rtd_pkg::ST_BAD_MAGIC;
                  res_valid_o   = 1'b1;
                  res_o.status  = rtd_pkg::ST_BAD_MAGIC;
                end else if (n_inc == 3'd4) begin
                  state_o.byte_cnt = 3'd0;
                  state_o.phase    = rtd_pkg::PH_HEADER;
                end else begin
                  state_o.byte_cnt = n_inc;
                end
              end
              rtd_pkg::PH_HEADER: begin
                state_o.byte_cnt = n_inc;
                case (n)
                  3'd0: state_o.width  = state_i.width | {8'd0, data_byte_i};
                  3'd1: state_o.width  = state_i.width | {data_byte_i, 8'd0};
                  3'd2: state_o.height = state_i.height | {8'd0, data_byte_i};
                  3'd3: state_o.height = state_i.height | {data_byte_i, 8'd0};
                  3'd4: begin
                    if ((data_byte_i == 8'd0) ||
                        (data_byte_i > 8'(rtd_pkg::MAX_CHANNELS))) begin
                      state_o.byte_cnt = n;
                      state_o.error    = rtd_pkg::ST_BAD_CHANNELS;
                      res_valid_o      = 1'b1;
                      res_o.status     = rtd_pkg::ST_BAD_CHANNELS;
                    end else begin
                      state_o.channels = data_byte_i[2:0];
                    end
                  end
                  default: begin
                    // reserved byte closes the header
                    if (n_inc == 3'd6) begin
                      state_o.total    = 32'(state_i.width) * 32'(state_i.height);
                      state_o.byte_cnt = 3'd0;
                      state_o.phase    = rtd_pkg::PH_RUNCOUNT;
                    end
                  end
                endcase
              end
              rtd_pkg::PH_RUNCOUNT: begin
                state_o.runs_left = state_i.runs_left | (byte_ext << sh);
                state_o.byte_cnt  = n_inc;
                if (n_inc == 3'd4) begin
                  state_o.byte_cnt = 3'd0;
                  state_o.phase    = (state_o.runs_left == 32'd0) ? rtd_pkg::PH_DONE
                                                                  : rtd_pkg::PH_RUNLEN;
                end
              end
              rtd_pkg::PH_RUNLEN: begin
                if (n == 3'd0) begin
                  state_o.run_len  = {8'd0, data_byte_i};
                  state_o.byte_cnt = n_inc;
                end else begin
                  state_o.run_len    = state_i.run_len | {data_byte_i, 8'd0};
                  state_o.byte_cnt   = 3'd0;
                  state_o.pixel_word = 32'd0;
                  state_o.phase      = rtd_pkg::PH_RUNPIX;
                end
              end
              rtd_pkg::PH_RUNPIX: begin
                state_o.pixel_word = state_i.pixel_word | (byte_ext << sh);
                state_o.byte_cnt   = n_inc;
                if (n_inc >= state_i.channels) begin
                  if (overflow) begin
                    state_o.error = rtd_pkg::ST_OVERFLOW;
                    res_valid_o   = 1'b1;
                    res_o.status  = rtd_pkg::ST_OVERFLOW;
                  end else begin
                    state_o.pending   = state_i.run_len;
                    state_o.runs_left = state_i.runs_left - 32'd1;
                    state_o.byte_cnt  = 3'd0;
                    state_o.phase     = (state_o.runs_left == 32'd0) ? rtd_pkg::PH_DONE
                                                                     : rtd_pkg::PH_RUNLEN;
                  end
                end
              end
              default: ; // trailing bytes are dropped
            endcase
          end
        end
      end
      rtd_pkg::REQ_PULL: begin
        if (!has_err && (state_i.pending != 16'd0)) begin
          res_valid_o       = 1'b1;
          res_o.kind        = rtd_pkg::KIND_PIXEL;
          res_o.pixel_value = state_i.pixel_word;
          res_o.last_pixel  = last;
          state_o.written   = state_i.written + 32'd1;
          state_o.pending   = state_i.pending - 16'd1;
        end
      end
      rtd_pkg::REQ_END: begin
        res_valid_o = 1'b1;
        if (has_err)      res_o.status = state_i.error;
        else if (done_ok) res_o.status = rtd_pkg::ST_OK;
        else              res_o.status = rtd_pkg::ST_INCOMPLETE;
      end
      default: ; // unknown request
    endcase
  end

endmodule

[src/rtd_out_reg.sv]
// ----------------------------------------------------------------------------
// rtd_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module rtd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rtd_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output rtd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  rtd_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i)           valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[test/rle_texture_decoder_core_test.sv]
// ----------------------------------------------------------------------------
// rle_texture_decoder_core_test
// Self-checking bench: CRT1 texture streams against a decoder shadow model.
// ----------------------------------------------------------------------------
// One file is streamed per run, since only reset clears the decoder. The
// seed picks the file: usually a well-formed image of random size and channel
// count cut into many short runs, sometimes a bad magic, a bad channel count,
// a huge image or an empty one. Ends, unused requests, stray pulls and
// refused bytes are mixed in. Every accepted item goes through a shadow
// decoder, and each result is checked field by field against the oldest
// prediction. Both handshake sides idle at random; the receiver also holds
// off for long stretches so the decoder backs up into its input.
// ----------------------------------------------------------------------------
module rle_texture_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the decoder must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Rough number of items per run
  localparam int unsigned ITEM_TARGET = 1200;

  typedef enum int {
    SCN_BAD_MAGIC,
    SCN_BAD_CHANNELS,
    SCN_WIDE,
    SCN_EMPTY,
    SCN_NORMAL
  } scenario_e;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
  } file_item_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = rtd_pkg::REQ_BYTE;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready;
  logic        rx_rdy = 1'b0;
  logic        rx_hold = 1'b0;
  logic        kind;
  logic [31:0] pixel_value;
  logic [31:0] pixel_index;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  channel_count;
  logic [2:0]  status;
  logic        last_pixel;

  file_item_t       file_items[$];
  rtd_pkg::result_t expected_results[$];
  // Shadow decoder state; reset happens once, so it starts at its reset value
  rtd_pkg::state_t  shadow = '0;
  int unsigned accepted_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  assign out_ready = rx_rdy & ~rx_hold;

  rle_texture_decoder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .pixel_value_o  (pixel_value),
    .pixel_index_o  (pixel_index),
    .image_width_o  (image_width),
    .image_height_o (image_height),
    .channel_count_o(channel_count),
    .status_o       (status),
    .last_pixel_o   (last_pixel)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow decoder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] magic_at(logic [1:0] idx);
    case (idx)
      2'd0:    return rtd_pkg::MAGIC_0;
      2'd1:    return rtd_pkg::MAGIC_1;
      2'd2:    return rtd_pkg::MAGIC_2;
      default: return rtd_pkg::MAGIC_3;
    endcase
  endfunction

  function automatic void expect_status(rtd_pkg::status_e st);
    rtd_pkg::result_t r;
    r = '0;
    r.kind          = rtd_pkg::KIND_STATUS;
    r.pixel_index   = shadow.written;
    r.image_width   = shadow.width;
    r.image_height  = shadow.height;
    r.channel_count = shadow.channels;
    r.status        = st;
    expected_results = {expected_results, r};
  endfunction

  function automatic void next_run_or_done();
    shadow.byte_cnt = 3'd0;
    shadow.phase    = (shadow.runs_left == 0) ? rtd_pkg::PH_DONE : rtd_pkg::PH_RUNLEN;
  endfunction

  // Feeds one file byte; returns the error it raises, or ST_OK
  function automatic rtd_pkg::status_e absorb_byte(logic [7:0] b);
    logic [2:0] n;
    int unsigned sh;
    n  = shadow.byte_cnt;
    sh = 8 * n[1:0];
    case (shadow.phase)
      rtd_pkg::PH_MAGIC: begin
        if (b != magic_at(n[1:0])) begin
          shadow.error = rtd_pkg::ST_BAD_MAGIC;
          return rtd_pkg::ST_BAD_MAGIC;
        end
        if (n == 3'd3) begin
          shadow.byte_cnt = 3'd0;
          shadow.phase    = rtd_pkg::PH_HEADER;
        end else begin
          shadow.byte_cnt = n + 3'd1;
        end
      end
      rtd_pkg::PH_HEADER: begin
        if (n < 3'd2) begin
          shadow.width = shadow.width | (16'(b) << sh);
        end else if (n < 3'd4) begin
          shadow.height = shadow.height | (16'(b) << (8 * (n - 3'd2)));
        end else if (n == 3'd4) begin
          if (b == 8'd0 || b > rtd_pkg::MAX_CHANNELS) begin
            shadow.error = rtd_pkg::ST_BAD_CHANNELS;
            return rtd_pkg::ST_BAD_CHANNELS;
          end
          shadow.channels = b[2:0];
        end
        // reserved byte closes the header
        if (n == 3'd5) begin
          shadow.total    = 32'(shadow.width) * 32'(shadow.height);
          shadow.byte_cnt = 3'd0;
          shadow.phase    = rtd_pkg::PH_RUNCOUNT;
        end else begin
          shadow.byte_cnt = n + 3'd1;
        end
      end
      rtd_pkg::PH_RUNCOUNT: begin
        shadow.runs_left = shadow.runs_left | (32'(b) << sh);
        if (n == 3'd3) next_run_or_done();
        else shadow.byte_cnt = n + 3'd1;
      end
      rtd_pkg::PH_RUNLEN: begin
        if (n == 3'd0) begin
          shadow.run_len  = 16'(b);
          shadow.byte_cnt = 3'd1;
        end else begin
          shadow.run_len[15:8] = b;
          shadow.byte_cnt      = 3'd0;
          shadow.pixel_word    = '0;
          shadow.phase         = rtd_pkg::PH_RUNPIX;
        end
      end
      rtd_pkg::PH_RUNPIX: begin
        shadow.pixel_word[sh +: 8] = b;
        if (32'(n) + 1 >= 32'(shadow.channels)) begin
          // run may not pass the image size
          if (64'(shadow.written) + 64'(shadow.run_len) > 64'(shadow.total)) begin
            shadow.error = rtd_pkg::ST_OVERFLOW;
            return rtd_pkg::ST_OVERFLOW;
          end
          shadow.pending   = shadow.run_len;
          shadow.runs_left = shadow.runs_left - 32'd1;
          next_run_or_done();
        end else begin
          shadow.byte_cnt = n + 3'd1;
        end
      end
      default: ;  // trailing bytes after the last run
    endcase
    return rtd_pkg::ST_OK;
  endfunction

  function automatic void decode_item(logic [1:0] req, logic [7:0] b);
    rtd_pkg::status_e st;
    rtd_pkg::result_t px;
    if (req == rtd_pkg::REQ_BYTE) begin
      if (shadow.error != rtd_pkg::ST_OK) return;
      if (shadow.pending != 0) begin
        expect_status(rtd_pkg::ST_REFUSED);
        return;
      end
      st = absorb_byte(b);
      if (st != rtd_pkg::ST_OK) expect_status(st);
    end else if (req == rtd_pkg::REQ_PULL) begin
      if (shadow.error != rtd_pkg::ST_OK || shadow.pending == 0) return;
      px = '0;
      px.kind          = rtd_pkg::KIND_PIXEL;
      px.pixel_value   = shadow.pixel_word;
      px.pixel_index   = shadow.written;
      px.image_width   = shadow.width;
      px.image_height  = shadow.height;
      px.channel_count = shadow.channels;
      px.status        = rtd_pkg::ST_OK;
      px.last_pixel    = (33'(shadow.written) + 33'd1 == 33'(shadow.total));
      expected_results = {expected_results, px};
      shadow.written = shadow.written + 32'd1;
      shadow.pending = shadow.pending - 16'd1;
    end else if (req == rtd_pkg::REQ_END) begin
      if (shadow.error != rtd_pkg::ST_OK) expect_status(shadow.error);
      else if (shadow.phase == rtd_pkg::PH_DONE && shadow.pending == 0 &&
               shadow.written == shadow.total) expect_status(rtd_pkg::ST_OK);
      else expect_status(rtd_pkg::ST_INCOMPLETE);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_item(logic [1:0] req, logic [7:0] data);
    file_item_t it;
    it.req  = req;
    it.data = data;
    file_items = {file_items, it};
  endtask

  // Occasional side item. While a run is pending a byte is refused, otherwise
  // a pull finds nothing to hand out.
  task automatic sprinkle(bit run_pending);
    if ($urandom_range(0, 11) != 0) return;
    case ($urandom_range(0, 2))
      0:       add_item(rtd_pkg::REQ_END, 8'($urandom_range(0, 255)));
      1:       add_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
      default: add_item(run_pending ? rtd_pkg::REQ_BYTE : rtd_pkg::REQ_PULL,
                        8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic put_file_byte(logic [7:0] b);
    sprinkle(1'b0);
    add_item(rtd_pkg::REQ_BYTE, b);
  endtask

  task automatic add_noise(int unsigned count);
    repeat (count) add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    scenario_e   scn;
    logic [15:0] w, h;
    logic [31:0] n_runs;
    logic [15:0] len16;
    logic [7:0]  b;
    int unsigned r, chans, budget, len, extra, bad_at;
    int unsigned run_lens[$];

    // From reset: nothing to pull, image incomplete, unused code ignored
    add_item(rtd_pkg::REQ_PULL, 8'h00);
    add_item(rtd_pkg::REQ_END, 8'hFF);
    add_item(REQ_UNUSED, 8'hFF);
    add_item(REQ_UNUSED, 8'h00);

    r = $urandom_range(0, 9);
    case (r)
      0:       scn = SCN_BAD_MAGIC;
      1:       scn = SCN_BAD_CHANNELS;
      2:       scn = SCN_WIDE;
      3:       scn = SCN_EMPTY;
      default: scn = SCN_NORMAL;
    endcase

    if (scn == SCN_BAD_MAGIC) begin
      bad_at = $urandom_range(0, 3);
      for (int i = 0; i < bad_at; i++) put_file_byte(magic_at(2'(i)));
      do b = 8'($urandom_range(0, 255)); while (b == magic_at(2'(bad_at)));
      add_item(rtd_pkg::REQ_BYTE, b);
      add_noise(ITEM_TARGET - file_items.size());
      add_item(rtd_pkg::REQ_END, 8'h00);
    end else if (scn == SCN_BAD_CHANNELS) begin
      for (int i = 0; i < 4; i++) put_file_byte(magic_at(2'(i)));
      repeat (4) put_file_byte(8'($urandom_range(0, 255)));
      put_file_byte($urandom_range(0, 1) ? 8'h00
                    : 8'($urandom_range(rtd_pkg::MAX_CHANNELS + 1, 255)));
      add_noise(ITEM_TARGET - file_items.size());
      add_item(rtd_pkg::REQ_END, 8'h00);
    end else begin
      chans = $urandom_range(1, rtd_pkg::MAX_CHANNELS);
      case (scn)
        SCN_WIDE: begin
          // huge image, never finished; only part of it is sent
          w = 16'hFFFF;
          h = 16'($urandom_range(1, 2));
          if ($urandom_range(0, 1)) {w, h} = {h, w};
          budget = 700;
        end
        SCN_EMPTY: begin
          w = 16'h0000;
          h = 16'($urandom_range(0, 65535));
          if ($urandom_range(0, 1)) {w, h} = {h, w};
          budget = 0;
        end
        default: begin
          w = 16'($urandom_range(1, 40));
          h = 16'(700 / w + $urandom_range(1, 9));
          budget = w * h;
        end
      endcase

      // Short runs mostly; the first ones are empty, single and double
      while (budget > 0 || run_lens.size() < 3) begin
        case (run_lens.size())
          0:       len = 0;
          1:       len = 1;
          2:       len = 2;
          default: len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400)
                                                      : $urandom_range(0, 8);
        endcase
        if (len > budget) len = budget;
        run_lens = {run_lens, len};
        budget -= len;
      end
      // at random, one extra declared run follows the image's own runs
      extra  = $urandom_range(0, 1);
      n_runs = 32'(run_lens.size() + extra);

      for (int i = 0; i < 4; i++) put_file_byte(magic_at(2'(i)));
      put_file_byte(w[7:0]);
      put_file_byte(w[15:8]);
      put_file_byte(h[7:0]);
      put_file_byte(h[15:8]);
      put_file_byte(8'(chans));
      put_file_byte(8'($urandom_range(0, 255)));
      for (int i = 0; i < 4; i++) put_file_byte(n_runs[8*i +: 8]);

      foreach (run_lens[i]) begin
        len16 = 16'(run_lens[i]);
        put_file_byte(len16[7:0]);
        put_file_byte(len16[15:8]);
        for (int c = 0; c < chans; c++) begin
          b = (i == 1) ? 8'hFF : (i == 2) ? 8'h00 : 8'($urandom_range(0, 255));
          put_file_byte(b);
        end
        for (int k = 0; k < run_lens[i]; k++) begin
          if (i == 2 && k == 1) add_item(rtd_pkg::REQ_BYTE, 8'hA5);  // refused mid-run
          else sprinkle(1'b1);
          add_item(rtd_pkg::REQ_PULL, 8'($urandom_range(0, 255)));
        end
      end
      add_item(rtd_pkg::REQ_END, 8'h00);

      if (extra != 0) begin
        len16 = 16'($urandom_range(1, 65535));
        put_file_byte(len16[7:0]);
        put_file_byte(len16[15:8]);
        repeat (chans) put_file_byte(8'($urandom_range(0, 255)));
        repeat (3) add_item(rtd_pkg::REQ_PULL, 8'h00);
        add_item(rtd_pkg::REQ_END, 8'h00);
      end
      // short files are padded with noise up to the usual item count
      add_noise((file_items.size() < ITEM_TARGET - 150) ? ITEM_TARGET - file_items.size()
                                                        : 150);
      add_item(rtd_pkg::REQ_END, 8'hFF);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges, once all clocked updates have settled
    do @(negedge clk_i);
    while (file_items.size() != 0 || in_valid || expected_results.size() != 0);
    // results land in the cycle after their item; allow a little slack
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Long receiver hold-offs so the output register fills and input stalls
  initial begin : rx_pressure
    int unsigned mark;
    mark = 150;
    repeat (2) begin
      do @(posedge clk_i); while (accepted_items < mark);
      rx_hold <= 1'b1;
      repeat ($urandom_range(40, 80)) @(posedge clk_i);
      rx_hold <= 1'b0;
      mark += 450;
    end
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin : driver
    file_item_t  nxt;
    int unsigned gap_now;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      req_type  <= rtd_pkg::REQ_BYTE;
      data_byte <= 8'h00;
      tx_gap    <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        decode_item(req_type, data_byte);
        accepted_items <= accepted_items + 1;
        if ($urandom_range(0, 149) == 0) tx_calm <= !tx_calm;
        gap_now = idle_len(tx_calm);
      end else begin
        gap_now = tx_gap;
      end
      if (gap_now == 0 && file_items.size() != 0) begin
        nxt = file_items.pop_front();
        in_valid  <= 1'b1;
        req_type  <= nxt.req;
        data_byte <= nxt.data;
        tx_gap    <= 0;
      end else begin
        in_valid <= 1'b0;
        tx_gap   <= (gap_now == 0) ? 0 : gap_now - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    // keep the log bounded on a badly broken block
    if (mismatch_count < 200) $display("%0t ns mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result();
    rtd_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no item waiting for one");
      return;
    end
    want = expected_results.pop_front();
    compare_field("kind", 32'(kind), 32'(want.kind));
    compare_field("pixel_value", pixel_value, want.pixel_value);
    compare_field("pixel_index", pixel_index, want.pixel_index);
    compare_field("image_width", 32'(image_width), 32'(want.image_width));
    compare_field("image_height", 32'(image_height), 32'(want.image_height));
    compare_field("channel_count", 32'(channel_count), 32'(want.channel_count));
    compare_field("status", 32'(status), 32'(want.status));
    compare_field("last_pixel", 32'(last_pixel), 32'(want.last_pixel));
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin : monitor
    if (!rst_ni) begin
      rx_rdy   <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (rx_stall != 0) begin
        rx_rdy   <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
        rx_rdy   <= 1'b0;
        rx_stall <= idle_len(1'b0);
      end else begin
        rx_rdy <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
    end
  end

endmodule

[rle_texture_decoder_core.f]
src/rtd_pkg.sv
src/rtd_step.sv
src/rtd_out_reg.sv
src/rle_texture_decoder_core.sv
test/rle_texture_decoder_core_test.sv
